// File: hdl/sia_pkg.sv
// Shared types and codes for the sorted interval allocation table.
package sia_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OVERLAP   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] length;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [10:0] slot;
    logic [31:0] found_base;
    logic [31:0] found_length;
    logic [10:0] live_count;
  } out_t;

endpackage

// File: hdl/sorted_interval_allocation_table_core.sv
// Top level: sorted region table with binary search and shifting insert/remove.
//
// Input channel in_valid/in_ready/in_data carries one operation per beat:
// insert a region (address, length), remove the region whose base equals
// address, or look up the region containing address. Output channel
// out_valid/out_ready/out_data returns exactly one result beat per operation.
// Regions live in one RAM of CAPACITY entries {base, length}, sorted by base.
// One operation is worked at a time. A binary search reads the RAM, then
// compares, for each probe, with up to log2(live)+1 probes, followed by a
// fetch and check of the found slot. Insert and remove then move every
// later entry by one place, one entry a cycle through the single RAM port
// pair, then drain the last write and, for insert, place the new entry.
// Lookup and rejected operations skip the move; an unused opcode goes
// straight to the response.
// The result sits in an output register; the next beat is taken as soon as
// the result is loaded, and a stalled receiver only holds the block when a
// second result is ready before the first has left.
// Reset clears the live count and the handshakes; the RAM needs no clearing.
module sorted_interval_allocation_table_core #(
  parameter int CAPACITY  = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sia_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sia_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int DW = ADDR_BITS + 32;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_CMP, S_FETCH, S_CHK, S_SHIFT, S_PUT, S_RESP
  } state_t;

  state_t                 state;
  logic [1:0]             op;
  logic [ADDR_BITS-1:0]   a;
  logic [31:0]            len;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [AW-1:0]          mid;
  logic                   in_region;
  logic                   nxt;
  logic [CW-1:0]          count;
  logic [AW-1:0]          rptr;
  logic [AW-1:0]          wptr;
  logic [CW-1:0]          n;
  logic                   pend;
  logic                   up;
  logic [1:0]             res_status;
  logic                   res_hit;
  logic [31:0]            res_fb;
  logic [31:0]            res_fl;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [DW-1:0]          ram_rdata;
  logic [ADDR_BITS-1:0]   rd_base;
  logic [31:0]            rd_len;
  logic [AW-1:0]          mid_calc;
  logic [CW-1:0]          half;

  assign rd_base  = ram_rdata[DW-1:32];
  assign rd_len   = ram_rdata[31:0];
  assign half     = (hi - lo) >> 1;
  assign mid_calc = AW'(lo + half);
  assign in_ready = (state == S_IDLE);

  sia_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Steer the RAM ports by state
  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = wptr;
    ram_wdata = ram_rdata;
    unique case (state)
      S_SRCH:  ram_raddr = mid_calc;
      S_FETCH: ram_raddr = AW'(lo);
      S_SHIFT: begin
        ram_raddr = rptr;
        ram_we    = pend;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(lo);
        ram_wdata = {a, len};
      end
      default: ram_raddr = '0;
    endcase
  end

  // Sequencer: search, check, move, respond
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // Load a fresh result or drop the one just taken
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= in_data.opcode;
            a          <= ADDR_BITS'(in_data.address);
            len        <= in_data.length;
            lo         <= '0;
            hi         <= count;
            in_region  <= 1'b0;
            nxt        <= 1'b0;
            res_status <= sia_pkg::ST_OK;
            res_hit    <= 1'b0;
            res_fb     <= '0;
            res_fl     <= '0;
            if (in_data.opcode == sia_pkg::OP_INSERT ||
                in_data.opcode == sia_pkg::OP_REMOVE ||
                in_data.opcode == sia_pkg::OP_LOOKUP) begin
              state <= S_SRCH;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_CMP;
          end else begin
            state <= S_FETCH;
          end
        end
        S_CMP: begin
          if (a < rd_base) begin
            hi    <= CW'(mid);
            state <= S_SRCH;
          end else if (LW'(a - rd_base) >= LW'(rd_len)) begin
            lo    <= CW'(mid) + 1'b1;
            state <= S_SRCH;
          end else begin
            in_region <= 1'b1;
            lo        <= CW'(mid);
            state     <= S_FETCH;
          end
        end
        S_FETCH: begin
          nxt   <= (lo < count);
          state <= S_CHK;
        end
        S_CHK: begin
          pend <= 1'b0;
          priority case (op)
            sia_pkg::OP_INSERT: begin
              up <= 1'b1;
              if (in_region || (nxt && LW'(len) > LW'(rd_base - a))) begin
                res_status <= sia_pkg::ST_OVERLAP;
                state      <= S_RESP;
              end else if (count == CW'(CAPACITY)) begin
                res_status <= sia_pkg::ST_FULL;
                state      <= S_RESP;
              end else begin
                rptr  <= AW'(count - 1'b1);
                n     <= count - lo;
                state <= S_SHIFT;
              end
            end
            sia_pkg::OP_REMOVE: begin
              up <= 1'b0;
              if (nxt && rd_base == a) begin
                res_hit <= 1'b1;
                res_fb  <= 32'(rd_base);
                res_fl  <= rd_len;
                rptr    <= AW'(lo + 1'b1);
                n       <= count - lo - 1'b1;
                count   <= count - 1'b1;
                state   <= S_SHIFT;
              end else begin
                res_status <= sia_pkg::ST_NOT_FOUND;
                state      <= S_RESP;
              end
            end
            default: begin
              up    <= 1'b0;
              state <= S_RESP;
              if (in_region) begin
                res_hit <= 1'b1;
                res_fb  <= 32'(rd_base);
                res_fl  <= rd_len;
              end else begin
                res_status <= sia_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
        S_SHIFT: begin
          // Read one entry ahead, write the one read last cycle
          if (n != '0) begin
            rptr <= up ? rptr - 1'b1 : rptr + 1'b1;
            wptr <= up ? rptr + 1'b1 : rptr - 1'b1;
            n    <= n - 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= up ? S_PUT : S_RESP;
            end
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_data.status       <= res_status;
            out_data.hit          <= res_hit;
            out_data.slot         <= 11'(lo);
            out_data.found_base   <= res_fb;
            out_data.found_length <= res_fl;
            out_data.live_count   <= 11'(count);
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Live count never passes the table size
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("live count above capacity");

  // RAM writes stay inside the live region plus the slot being opened
  assert property (@(posedge clk) disable iff (rst) ram_we |-> CW'(ram_waddr) <= count)
    else $error("RAM write beyond live entries");

  // The response step, once the output is free, loads a result and returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");

  // An accepted beat starts work at once
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> state != S_IDLE)
    else $error("accepted beat dropped");

endmodule

// File: hdl/sia_ram.sv
// Generic simple dual-port RAM with a registered read port.
module sia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry and read one entry; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
